/* hdl/mebp_pkg.sv */
// Package with the shared constants, state encoding and command and status types.
package mebp_pkg;

	localparam int DEPTH = 1024;
	localparam int ADDR_W = $clog2(DEPTH);
	localparam int LEN_W = 11;
	localparam int DATA_W = 32;
	localparam int REG_IDX_W = 2;
	localparam int CFG_W = LEN_W;
	localparam int S_TDATA_W = 176;
	localparam int M_TDATA_W = 4 * DATA_W;

	localparam logic [REG_IDX_W-1:0] REG_DIRECTION = 2'd0;
	localparam logic [REG_IDX_W-1:0] REG_ONE_BASED = 2'd1;
	localparam logic [REG_IDX_W-1:0] REG_TABLE_LENGTH = 2'd2;

	localparam logic REQ_LOAD = 1'b0;
	localparam logic REQ_PROPAGATE = 1'b1;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_CLIP,
		ST_RD_LO,
		ST_RD_HI,
		ST_ENDS,
		ST_PROBE,
		ST_CMP,
		ST_SEARCH_END,
		ST_FINAL,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic load;
		logic capture;
		logic clip;
		logic rd_lo;
		logic rd_hi;
		logic ends;
		logic probe;
		logic cmp;
		logic search_end;
		logic fin;
		logic set_fail;
		logic out_load;
	} cmd_t;

	typedef struct packed {
		logic early_fail;
		logic ends_fail;
		logic count_zero;
		logic end_fail;
		logic second_search;
		logic fin_fail;
	} status_t;

endpackage

/* hdl/mebp_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
module mebp_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

/* hdl/mebp_ctrl.sv */
// Controller state machine that sequences clipping, end reads, both searches and output.
module mebp_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_tvalid,
	output logic             s_tready,
	input  logic             req_type,
	output logic             m_tvalid,
	input  logic             m_tready,
	input  mebp_pkg::status_t st,
	output mebp_pkg::cmd_t   cmd
);
	import mebp_pkg::*;

	state_t state_q, state_d;
	logic out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign m_tvalid = out_valid_q;
	assign s_tready = (state_q == ST_IDLE);

	always_comb begin
		state_d = state_q;
		cmd = '0;
		case (state_q)
			ST_IDLE: begin
				if (s_tvalid) begin
					if (req_type == REQ_PROPAGATE) begin
						cmd.capture = 1'b1;
						state_d = ST_CLIP;
					end else begin
						cmd.load = 1'b1;
					end
				end
			end
			ST_CLIP: begin
				cmd.clip = 1'b1;
				if (st.early_fail) begin
					cmd.set_fail = 1'b1;
					state_d = ST_DONE;
				end else begin
					state_d = ST_RD_LO;
				end
			end
			ST_RD_LO: begin
				cmd.rd_lo = 1'b1;
				state_d = ST_RD_HI;
			end
			ST_RD_HI: begin
				cmd.rd_hi = 1'b1;
				state_d = ST_ENDS;
			end
			ST_ENDS: begin
				cmd.ends = 1'b1;
				if (st.ends_fail) begin
					cmd.set_fail = 1'b1;
					state_d = ST_DONE;
				end else begin
					state_d = ST_PROBE;
				end
			end
			ST_PROBE: begin
				if (st.count_zero) begin
					state_d = ST_SEARCH_END;
				end else begin
					cmd.probe = 1'b1;
					state_d = ST_CMP;
				end
			end
			ST_CMP: begin
				cmd.cmp = 1'b1;
				state_d = ST_PROBE;
			end
			ST_SEARCH_END: begin
				cmd.search_end = 1'b1;
				if (st.end_fail) begin
					cmd.set_fail = 1'b1;
					state_d = ST_DONE;
				end else if (st.second_search) begin
					state_d = ST_FINAL;
				end else begin
					state_d = ST_PROBE;
				end
			end
			ST_FINAL: begin
				cmd.fin = 1'b1;
				cmd.set_fail = st.fin_fail;
				state_d = ST_DONE;
			end
			ST_DONE: begin
				if (!out_valid_q || m_tready) begin
					cmd.out_load = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

/* hdl/mebp_dp.sv */
// Datapath with configuration registers, table memory, bound arithmetic and search registers.
module mebp_dp (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_wr_en,
	input  logic [mebp_pkg::REG_IDX_W-1:0] cfg_index,
	input  logic [mebp_pkg::CFG_W-1:0]    cfg_wr_data,
	input  logic [mebp_pkg::ADDR_W-1:0]   entry_addr,
	input  logic signed [mebp_pkg::DATA_W-1:0] entry_value,
	input  logic signed [mebp_pkg::DATA_W-1:0] index_min,
	input  logic signed [mebp_pkg::DATA_W-1:0] index_max,
	input  logic signed [mebp_pkg::DATA_W-1:0] result_min,
	input  logic signed [mebp_pkg::DATA_W-1:0] result_max,
	input  mebp_pkg::cmd_t                cmd,
	output mebp_pkg::status_t             st,
	output logic                          fail,
	output logic signed [mebp_pkg::DATA_W-1:0] new_index_min,
	output logic signed [mebp_pkg::DATA_W-1:0] new_index_max,
	output logic signed [mebp_pkg::DATA_W-1:0] new_result_min,
	output logic signed [mebp_pkg::DATA_W-1:0] new_result_max
);
	import mebp_pkg::*;

	localparam int WIDE_W = DATA_W + 2;

	logic             dir_q;
	logic             one_q;
	logic [LEN_W-1:0] len_q;

	logic signed [DATA_W-1:0] imin_q, imax_q, rmin_q, rmax_q;
	logic signed [DATA_W-1:0] ea_q;
	logic [ADDR_W-1:0] lo_q, hi_q, nlo_q, nhi_q;
	logic [LEN_W-1:0]  first_q, count_q, step_q;
	logic              sel_q;
	logic              fail_q;

	logic [ADDR_W-1:0]        raddr;
	logic signed [DATA_W-1:0] rdata;

	logic [LEN_W-1:0]         n_w;
	logic signed [WIDE_W-1:0] off_w, lo0_w, hi0_w, hi_lim_w, lo_c_w, hi_c_w;
	logic signed [DATA_W-1:0] elo_w, ehi_w, nrmin_w, nrmax_w, key_w;
	logic [LEN_W-1:0]         span_w, half_w, pos_w;
	logic                     lt_w, eq_w, pred_w;
	logic signed [DATA_W:0]   cand_lo_w, cand_hi_w, imin_x_w, imax_x_w, nimin_w, nimax_w;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dir_q <= 1'b0;
			one_q <= 1'b0;
			len_q <= '0;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				REG_DIRECTION: dir_q <= cfg_wr_data[0];
				REG_ONE_BASED: one_q <= cfg_wr_data[0];
				REG_TABLE_LENGTH: len_q <= cfg_wr_data;
				default: ;
			endcase
		end
	end

	mebp_ram #(
		.WIDTH(DATA_W),
		.DEPTH(DEPTH)
	) u_ram (
		.clk(clk),
		.we(cmd.load),
		.waddr(entry_addr),
		.wdata(entry_value),
		.raddr(raddr),
		.rdata(rdata)
	);

	always_comb begin
		n_w = (len_q > LEN_W'(DEPTH)) ? LEN_W'(DEPTH) : len_q;
		off_w = $signed({{(WIDE_W-1){1'b0}}, one_q});
		lo0_w = $signed({{2{imin_q[DATA_W-1]}}, imin_q}) - off_w;
		hi0_w = $signed({{2{imax_q[DATA_W-1]}}, imax_q}) - off_w;
		hi_lim_w = $signed({{(WIDE_W-LEN_W){1'b0}}, n_w}) - WIDE_W'(1);
		lo_c_w = (lo0_w < 0) ? '0 : lo0_w;
		hi_c_w = (hi0_w > hi_lim_w) ? hi_lim_w : hi0_w;
		st.early_fail = (n_w == '0) || (imin_q > imax_q) || (rmin_q > rmax_q)
			|| (lo_c_w > hi_c_w);

		elo_w = dir_q ? rdata : ea_q;
		ehi_w = dir_q ? ea_q : rdata;
		nrmin_w = (elo_w > rmin_q) ? elo_w : rmin_q;
		nrmax_w = (ehi_w < rmax_q) ? ehi_w : rmax_q;
		st.ends_fail = nrmin_w > nrmax_w;

		span_w = {1'b0, hi_q} - {1'b0, lo_q} + LEN_W'(1);
		half_w = count_q >> 1;
		pos_w = first_q + (cmd.probe ? half_w : step_q);
		st.count_zero = (count_q == '0);

		key_w = (sel_q ^ dir_q) ? rmax_q : rmin_q;
		lt_w = rdata < key_w;
		eq_w = rdata == key_w;
		pred_w = dir_q ^ (lt_w | (eq_w & (sel_q ^ dir_q)));

		st.second_search = sel_q;
		st.end_fail = sel_q ? (first_q == {1'b0, lo_q})
			: (first_q == ({1'b0, hi_q} + LEN_W'(1)));

		cand_lo_w = $signed({{(DATA_W+1-ADDR_W){1'b0}}, nlo_q}) + $signed({{DATA_W{1'b0}}, one_q});
		cand_hi_w = $signed({{(DATA_W+1-ADDR_W){1'b0}}, nhi_q}) + $signed({{DATA_W{1'b0}}, one_q});
		imin_x_w = $signed({imin_q[DATA_W-1], imin_q});
		imax_x_w = $signed({imax_q[DATA_W-1], imax_q});
		nimin_w = (cand_lo_w > imin_x_w) ? cand_lo_w : imin_x_w;
		nimax_w = (cand_hi_w < imax_x_w) ? cand_hi_w : imax_x_w;
		st.fin_fail = nimin_w > nimax_w;

		if (cmd.rd_lo) begin
			raddr = lo_q;
		end else if (cmd.rd_hi) begin
			raddr = hi_q;
		end else begin
			raddr = pos_w[ADDR_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fail_q <= 1'b0;
			sel_q <= 1'b0;
		end else begin
			if (cmd.capture) begin
				fail_q <= 1'b0;
			end else if (cmd.set_fail) begin
				fail_q <= 1'b1;
			end
			if (cmd.ends) begin
				sel_q <= 1'b0;
			end else if (cmd.search_end) begin
				sel_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			imin_q <= index_min;
			imax_q <= index_max;
			rmin_q <= result_min;
			rmax_q <= result_max;
		end
		if (cmd.clip) begin
			lo_q <= lo_c_w[ADDR_W-1:0];
			hi_q <= hi_c_w[ADDR_W-1:0];
		end
		if (cmd.rd_hi) begin
			ea_q <= rdata;
		end
		if (cmd.ends) begin
			rmin_q <= nrmin_w;
			rmax_q <= nrmax_w;
			first_q <= {1'b0, lo_q};
			count_q <= span_w;
		end
		if (cmd.probe) begin
			step_q <= half_w;
		end
		if (cmd.cmp) begin
			if (pred_w) begin
				first_q <= pos_w + LEN_W'(1);
				count_q <= count_q - step_q - LEN_W'(1);
			end else begin
				count_q <= step_q;
			end
		end
		if (cmd.search_end) begin
			if (!sel_q) begin
				nlo_q <= first_q[ADDR_W-1:0];
				first_q <= {1'b0, lo_q};
				count_q <= span_w;
			end else begin
				nhi_q <= ADDR_W'(first_q - LEN_W'(1));
			end
		end
		if (cmd.fin) begin
			imin_q <= nimin_w[DATA_W-1:0];
			imax_q <= nimax_w[DATA_W-1:0];
		end
		if (cmd.out_load) begin
			fail <= fail_q;
			new_index_min <= fail_q ? '0 : imin_q;
			new_index_max <= fail_q ? '0 : imax_q;
			new_result_min <= fail_q ? '0 : rmin_q;
			new_result_max <= fail_q ? '0 : rmax_q;
		end
	end

endmodule

/* hdl/monotonic_element_bounds_propagator.sv */
// Top level of the monotonic element bounds propagator with stream ports and config port.
// A load beat writes its table entry, and loads can follow back to back.
// A propagate beat runs clipping, the end reads and both searches, or stops early on a fail,
// before its result is registered; how long it takes depends on the probes of both searches.
// Ready returns with the result, so the next beat waits for it and for any output stall.
// Reset clears the configuration registers and the controller; table entries are undefined.
module monotonic_element_bounds_propagator (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_wr_en,
	input  logic [mebp_pkg::REG_IDX_W-1:0]   cfg_index,
	input  logic [mebp_pkg::CFG_W-1:0]       cfg_wr_data,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	// entry_addr, entry_value, index_min, index_max, result_min, result_max, zero fill
	input  logic [mebp_pkg::S_TDATA_W-1:0]   s_tdata,
	// req_type
	input  logic                             s_tuser,
	output logic                             m_tvalid,
	input  logic                             m_tready,
	// new_index_min, new_index_max, new_result_min, new_result_max
	output logic [mebp_pkg::M_TDATA_W-1:0]   m_tdata,
	// fail
	output logic                             m_tuser
);
	import mebp_pkg::*;

	localparam int VAL0 = ADDR_W;

	cmd_t    cmd;
	status_t st;
	logic signed [DATA_W-1:0] o_imin, o_imax, o_rmin, o_rmax;

	mebp_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.req_type(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.st(st),
		.cmd(cmd)
	);

	mebp_dp u_dp (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en),
		.cfg_index(cfg_index),
		.cfg_wr_data(cfg_wr_data),
		.entry_addr(s_tdata[ADDR_W-1:0]),
		.entry_value(s_tdata[VAL0 +: DATA_W]),
		.index_min(s_tdata[VAL0 + DATA_W +: DATA_W]),
		.index_max(s_tdata[VAL0 + 2*DATA_W +: DATA_W]),
		.result_min(s_tdata[VAL0 + 3*DATA_W +: DATA_W]),
		.result_max(s_tdata[VAL0 + 4*DATA_W +: DATA_W]),
		.cmd(cmd),
		.st(st),
		.fail(m_tuser),
		.new_index_min(o_imin),
		.new_index_max(o_imax),
		.new_result_min(o_rmin),
		.new_result_max(o_rmax)
	);

	assign m_tdata = {o_rmax, o_rmin, o_imax, o_imin};

endmodule
